/* hw/rtl/swrm_pkg.sv */
// ---------------------------------------------------------------------------
// swrm_pkg: shared types and constants of the sliding window rate meter
// Field widths, the slot layout of the history store, opcodes and the
// sequencer states.
// ---------------------------------------------------------------------------
`default_nettype none

package swrm_pkg;

  localparam int DATA_W    = 32;  // seconds, byte sums and the rate
  localparam int SPAN_W    = 33;  // divisor: wrapped second difference plus one
  localparam int COUNT_W   = 16;  // byte count of one item
  localparam int WIN_W     = 4;   // window register
  localparam int HELD_W    = 5;   // entries_held result field

  localparam logic [WIN_W-1:0] WINDOW_RESET = 4'd3;

  localparam logic OP_RECEIVE = 1'b0;  // record bytes, then trim and report
  localparam logic OP_REPORT  = 1'b1;  // trim and report only

  typedef struct packed {
    logic [DATA_W-1:0] second;
    logic [DATA_W-1:0] bytes;
  } slot_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REC_RD,
    S_REC_CHK,
    S_TRIM_RD,
    S_TRIM_CHK,
    S_SUM_INIT,
    S_SUM_RD,
    S_SUM_ACC,
    S_DIV_START,
    S_DIV_WAIT,
    S_DONE
  } swrm_state_t;

endpackage

`default_nettype wire

/* hw/rtl/swrm_ram.sv */
// ---------------------------------------------------------------------------
// swrm_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module swrm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/swrm_div.sv */
// ---------------------------------------------------------------------------
// swrm_div: serial restoring divider
// The dividend shifts out of a register one bit per cycle into the partial
// remainder while the quotient shifts in behind it; one quotient bit a cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module swrm_div
  import swrm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DATA_W-1:0] dividend,
  input  wire logic [SPAN_W-1:0] divisor,
  output logic                   done,
  output logic      [DATA_W-1:0] quotient
);

  localparam int BIT_CNT_W = $clog2(DATA_W + 1);

  logic                 busy;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [SPAN_W-1:0]    rem;
  logic [SPAN_W-1:0]    dvs;
  logic [DATA_W-1:0]    quo;
  logic [SPAN_W+1:0]    diff;
  logic                 fits;

  // Trial subtraction of the divisor from the remainder with the next
  // dividend bit shifted in; the borrow tells whether it fits.
  assign diff = {1'b0, rem, quo[DATA_W-1]} - {2'b00, dvs};
  assign fits = ~diff[SPAN_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        bit_cnt <= BIT_CNT_W'(DATA_W);
        rem     <= '0;
        quo     <= dividend;
        dvs     <= divisor;
      end else if (busy) begin
        rem     <= fits ? diff[SPAN_W-1:0] : {rem[SPAN_W-2:0], quo[DATA_W-1]};
        quo     <= {quo[DATA_W-2:0], fits};
        bit_cnt <= bit_cnt - 1'b1;
        if (bit_cnt == BIT_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

/* hw/rtl/sliding_window_rate_meter.sv */
// ---------------------------------------------------------------------------
// sliding_window_rate_meter: windowed throughput from per-second byte counts
// Keeps a circular history of per-second byte sums and reports, for every
// item, the rate over the window excluding the newest second.
// ---------------------------------------------------------------------------
// Each item carries an opcode, the current second and a byte count. A receive
// item adds its bytes to the newest history entry when that entry holds the
// same second, and starts a new entry otherwise; when MAX_ENTRIES entries are
// already held, the new entry replaces the oldest. Both opcodes then drop
// every entry older than now_seconds minus window_seconds (nothing is dropped
// while now_seconds is below the window) and return one result item: the
// saturated byte sum of all held entries but the newest, divided by the span
// from the oldest entry's second to the second-newest entry's second plus
// one, together with the number of entries kept. With fewer than two entries
// the rate is zero. The block works on one item at a time; item_stall is high
// from the cycle after an item is taken until its result is loaded into the
// output register, and a result waiting there does not hold up the next item,
// although the next result then waits in the last sequencer state until the
// output register has been emptied.
// The history lives in a RAM with registered read data, so the record step,
// the trim walk and the sum walk each spend a read state and a check or add
// state on each entry they visit; the serial divider is started from its own
// state and then waited for. With fewer than two entries held the divide is
// skipped. The history RAM is not cleared after reset; only entries counted
// as held are ever used.
// window_seconds is written through the cfg port, which is always ready and
// must only be used while no item is in flight.
// ---------------------------------------------------------------------------
`default_nettype none

module sliding_window_rate_meter
  import swrm_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // Configuration write channel: window_seconds.
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [WIN_W-1:0]   cfg_data,
  // Input items.
  input  wire logic               item_valid,
  output logic                    item_stall,
  input  wire logic               opcode,
  input  wire logic [DATA_W-1:0]  now_seconds,
  input  wire logic [COUNT_W-1:0] byte_count,
  // Result items.
  output logic                    result_valid,
  input  wire logic               result_stall,
  output logic      [DATA_W-1:0]  rate_bytes_per_second,
  output logic      [HELD_W-1:0]  entries_held
);

  localparam int PTR_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [PTR_W:0]   MAX_W   = (PTR_W + 1)'(MAX_ENTRIES);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(MAX_ENTRIES - 1);

  // Slot that lies 'back' entries behind 'base' in the circular store.
  function automatic logic [PTR_W-1:0] slot_back(input logic [PTR_W-1:0] base,
                                                 input logic [CNT_W-1:0] back);
    logic [PTR_W:0] s;
    s = {1'b0, base} + (MAX_W - (PTR_W + 1)'(back));
    if (s >= MAX_W) begin
      s = s - MAX_W;
    end
    return s[PTR_W-1:0];
  endfunction

  swrm_state_t state, state_next;

  // Architectural state.
  logic [WIN_W-1:0]   window;
  logic [PTR_W-1:0]   newest;
  logic [CNT_W-1:0]   held;

  // Item being worked on.
  logic [DATA_W-1:0]  now_r;
  logic [COUNT_W-1:0] bytes_r;
  logic [DATA_W-1:0]  limit;
  logic               trim_en;

  // Walk and result registers.
  logic [CNT_W-1:0]   k;
  logic [DATA_W-1:0]  sum;
  logic [DATA_W-1:0]  second_hi;
  logic [DATA_W-1:0]  second_lo;
  logic [DATA_W-1:0]  rate;

  // History RAM ports.
  logic               ram_wr_en;
  logic [PTR_W-1:0]   ram_wr_addr;
  slot_t              ram_wr_data;
  logic               ram_rd_en;
  logic [PTR_W-1:0]   ram_rd_addr;
  slot_t              ram_rd_data;

  // Divider ports.
  logic               div_start;
  logic               div_done;
  logic [SPAN_W-1:0]  div_span;
  logic [DATA_W-1:0]  div_quotient;

  // Decisions taken on the registered RAM data, the walk counter and the output handshake.
  logic               rec_hit;
  logic [PTR_W-1:0]   newest_inc;
  logic [DATA_W:0]    rec_add;
  logic [DATA_W-1:0]  rec_sat;
  logic               trim_go;
  logic               too_old;
  logic               sum_last;
  logic [DATA_W:0]    acc_add;
  logic [DATA_W-1:0]  acc_sat;
  logic               res_take;

  swrm_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (MAX_ENTRIES)
  ) u_hist (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  swrm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (div_span),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // A receive item merges into the newest entry only when one is held and it
  // carries the same second.
  assign rec_hit    = (held != '0) && (ram_rd_data.second == now_r);
  assign newest_inc = (newest == LAST_PTR) ? '0 : newest + 1'b1;
  assign rec_add    = {1'b0, ram_rd_data.bytes} + (DATA_W + 1)'(bytes_r);
  assign rec_sat    = rec_add[DATA_W] ? '1 : rec_add[DATA_W-1:0];

  // The trim walk looks at the oldest held entry each round.
  assign trim_go = trim_en && (held != '0);
  assign too_old = ram_rd_data.second < limit;

  // The sum walk runs from the second-newest entry back to the oldest.
  assign sum_last = (k == held - 1'b1);
  assign acc_add  = {1'b0, sum} + {1'b0, ram_rd_data.bytes};
  assign acc_sat  = acc_add[DATA_W] ? '1 : acc_add[DATA_W-1:0];

  // Span in 33 bits so that it can never be zero.
  assign div_span = {1'b0, second_hi - second_lo} + SPAN_W'(1);

  // The output register can be loaded when it is empty or being emptied.
  assign res_take = ~result_valid | ~result_stall;

  assign cfg_ready = 1'b1;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          state_next = (opcode == OP_RECEIVE) ? S_REC_RD : S_TRIM_RD;
        end
      end
      S_REC_RD:    state_next = S_REC_CHK;
      S_REC_CHK:   state_next = S_TRIM_RD;
      S_TRIM_RD:   state_next = trim_go ? S_TRIM_CHK : S_SUM_INIT;
      S_TRIM_CHK:  state_next = too_old ? S_TRIM_RD : S_SUM_INIT;
      S_SUM_INIT:  state_next = (held < CNT_W'(2)) ? S_DONE : S_SUM_RD;
      S_SUM_RD:    state_next = S_SUM_ACC;
      S_SUM_ACC:   state_next = sum_last ? S_DIV_START : S_SUM_RD;
      S_DIV_START: state_next = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default:     state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs: RAM ports, divider start and the input stall.
  always_comb begin
    item_stall         = 1'b1;
    ram_rd_en          = 1'b0;
    ram_rd_addr        = newest;
    ram_wr_en          = 1'b0;
    ram_wr_addr        = rec_hit ? newest : newest_inc;
    ram_wr_data.second = now_r;
    ram_wr_data.bytes  = rec_hit ? rec_sat : DATA_W'(bytes_r);
    div_start          = 1'b0;
    unique case (state)
      S_IDLE: begin
        item_stall = 1'b0;
      end
      S_REC_RD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = newest;
      end
      S_REC_CHK: begin
        ram_wr_en = 1'b1;
      end
      S_TRIM_RD: begin
        ram_rd_en   = trim_go;
        ram_rd_addr = slot_back(newest, held - 1'b1);
      end
      S_SUM_RD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = slot_back(newest, k);
      end
      S_DIV_START: begin
        div_start = 1'b1;
      end
      S_TRIM_CHK, S_SUM_INIT, S_SUM_ACC, S_DIV_WAIT, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      window       <= WINDOW_RESET;
      newest       <= '0;
      held         <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        window <= cfg_data;
      end
      if (state == S_REC_CHK && !rec_hit) begin
        newest <= newest_inc;
        if (held != MAX_CNT) begin
          held <= held + 1'b1;
        end
      end
      if (state == S_TRIM_CHK && too_old) begin
        held <= held - 1'b1;
      end
      if (state == S_DONE && res_take) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload and walk registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && item_valid) begin
      now_r    <= now_seconds;
      bytes_r  <= byte_count;
      limit    <= now_seconds - DATA_W'(window);
      trim_en  <= now_seconds >= DATA_W'(window);
    end
    if (state == S_SUM_INIT) begin
      k   <= CNT_W'(1);
      sum <= '0;
      if (held < CNT_W'(2)) begin
        rate <= '0;
      end
    end
    if (state == S_SUM_ACC) begin
      sum <= acc_sat;
      k   <= k + 1'b1;
      if (k == CNT_W'(1)) begin
        second_hi <= ram_rd_data.second;
      end
      if (sum_last) begin
        second_lo <= ram_rd_data.second;
      end
    end
    if (state == S_DIV_WAIT && div_done) begin
      rate <= div_quotient;
    end
    if (state == S_DONE && res_take) begin
      rate_bytes_per_second <= rate;
      entries_held          <= HELD_W'(held);
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/swrm_checker.sv */
// ---------------------------------------------------------------------------
// swrm_checker: port-level assertions for the sliding window rate meter
// Watches the top-level ports only and is bound to every instance.
// ---------------------------------------------------------------------------
`default_nettype none

module swrm_checker
  import swrm_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               item_valid,
  input wire logic               item_stall,
  input wire logic               result_valid,
  input wire logic               result_stall,
  input wire logic [DATA_W-1:0]  rate_bytes_per_second,
  input wire logic [HELD_W-1:0]  entries_held
);

  localparam bit COUNT_FITS = MAX_ENTRIES < 32;

  // A stalled result keeps its valid and its payload.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(rate_bytes_per_second) && $stable(entries_held))
    else $error("result changed while stalled");

  // One item at a time: the cycle after an item is taken the input stalls.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("second item taken while one is in flight");

  // The held count never exceeds the history depth.
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid && COUNT_FITS |-> entries_held <= HELD_W'(MAX_ENTRIES))
    else $error("entries_held above depth");

  // Fewer than two entries always report a zero rate.
  a_rate_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && COUNT_FITS && (entries_held < HELD_W'(2)) |->
      rate_bytes_per_second == '0)
    else $error("nonzero rate with fewer than two entries");

endmodule

bind sliding_window_rate_meter swrm_checker #(
  .MAX_ENTRIES (MAX_ENTRIES)
) u_swrm_checker (.*);

`default_nettype wire

/* verif/swrm_checker.sv */
// ---------------------------------------------------------------------------
// swrm_scoreboard: result predictor and scoreboard for the rate meter
// Watches the config, item and result channels, keeps its own copy of the
// per-second history and compares each result item with its prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module swrm_scoreboard
  import swrm_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire logic [WIN_W-1:0]   cfg_data,
  input  wire logic               item_valid,
  input  wire logic               item_stall,
  input  wire logic               opcode,
  input  wire logic [DATA_W-1:0]  now_seconds,
  input  wire logic [COUNT_W-1:0] byte_count,
  input  wire logic               result_valid,
  input  wire logic               result_stall,
  input  wire logic [DATA_W-1:0]  rate_bytes_per_second,
  input  wire logic [HELD_W-1:0]  entries_held,
  output int                      fail_count,
  output int                      pending
);

  typedef struct packed {
    logic [DATA_W-1:0] rate;
    logic [HELD_W-1:0] held;
  } rate_result_t;

  logic [DATA_W-1:0] hist_second [MAX_ENTRIES];
  logic [DATA_W-1:0] hist_bytes  [MAX_ENTRIES];
  int                newest;
  int                held;
  logic [WIN_W-1:0]  window;
  rate_result_t      rate_expected_q [$];
  int                mismatches;

  function automatic int slot_back(input int back);
    return (newest + MAX_ENTRIES - back) % MAX_ENTRIES;
  endfunction

  // Updates the history with one item and returns the rate it reports.
  function automatic rate_result_t advance_history(input logic op,
                                                   input logic [DATA_W-1:0] now,
                                                   input logic [COUNT_W-1:0] cnt);
    logic [DATA_W:0]   entry_sum;
    logic [DATA_W-1:0] limit;
    logic [63:0]       sum;
    logic [63:0]       span;
    rate_result_t      r;
    if (op == OP_RECEIVE) begin
      if (held > 0 && hist_second[newest] == now) begin
        entry_sum = {1'b0, hist_bytes[newest]} + (DATA_W + 1)'(cnt);
        hist_bytes[newest] = entry_sum[DATA_W] ? '1 : entry_sum[DATA_W-1:0];
      end else begin
        newest = (newest + 1) % MAX_ENTRIES;
        hist_second[newest] = now;
        hist_bytes[newest] = DATA_W'(cnt);
        if (held < MAX_ENTRIES) held++;
      end
    end
    if (now >= DATA_W'(window)) begin
      limit = now - DATA_W'(window);
      while (held > 0 && hist_second[slot_back(held - 1)] < limit) held--;
    end
    r.rate = '0;
    if (held >= 2) begin
      sum = '0;
      for (int k = 1; k < held; k++) begin
        sum += hist_bytes[slot_back(k)];
        if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
      end
      span = 64'(DATA_W'(hist_second[slot_back(1)] - hist_second[slot_back(held - 1)])) + 1;
      r.rate = DATA_W'(sum / span);
    end
    r.held = HELD_W'(held);
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    rate_result_t exp_r;
    if (rst) begin
      newest = 0;
      held = 0;
      window = WINDOW_RESET;
      rate_expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) window = cfg_data;
      if (item_valid && !item_stall)
        rate_expected_q.push_back(advance_history(opcode, now_seconds, byte_count));
      if (result_valid && !result_stall) begin
        if (rate_expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result item: rate %0d held %0d", $realtime,
                     rate_bytes_per_second, entries_held);
        end else begin
          exp_r = rate_expected_q.pop_front();
          if (exp_r.rate !== rate_bytes_per_second || exp_r.held !== entries_held) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: result mismatch: expected rate %0d held %0d, got rate %0d held %0d",
                       $realtime, exp_r.rate, exp_r.held, rate_bytes_per_second,
                       entries_held);
          end
        end
      end
    end
    pending    <= rate_expected_q.size();
    fail_count <= mismatches;
  end

endmodule

/* verif/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top: stimulus and verdict for the sliding window rate meter
// Drives a directed sequence and then random phases at several window
// settings, with random gaps on the item side and random stalls on the
// result side; checking is done by the checker instantiated next to the DUT.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import swrm_pkg::*;

  localparam int MAX_ENTRIES      = 16;
  localparam int PHASES           = 8;
  localparam int ITEMS_PER_PHASE  = 180;
  // The limit is well above the sum, over all items, of the worst case block
  // time, the longest sender gap and the longest result stall.
  localparam int CYCLE_LIMIT      = 3_000_000;
  localparam int LONG_HOLD_CYCLES = 600;
  localparam int IDLE_SETTLE      = 4;
  localparam int END_WAIT         = 200;

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [WIN_W-1:0]   cfg_data;
  logic               item_valid;
  logic               item_stall;
  logic               opcode;
  logic [DATA_W-1:0]  now_seconds;
  logic [COUNT_W-1:0] byte_count;
  logic               result_valid;
  logic               result_stall;
  logic [DATA_W-1:0]  rate_bytes_per_second;
  logic [HELD_W-1:0]  entries_held;

  int fail_count;
  int pending;
  int cycle_count;
  int cur_window = 3;

  // Requests from the stimulus to the result side pacing process.
  bit hold_request = 1'b0;
  bit quiet        = 1'b0;

  sliding_window_rate_meter #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) dut (
    .clk                  (clk),
    .rst                  (rst),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_data             (cfg_data),
    .item_valid           (item_valid),
    .item_stall           (item_stall),
    .opcode               (opcode),
    .now_seconds          (now_seconds),
    .byte_count           (byte_count),
    .result_valid         (result_valid),
    .result_stall         (result_stall),
    .rate_bytes_per_second(rate_bytes_per_second),
    .entries_held         (entries_held)
  );

  swrm_scoreboard #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_checker (
    .clk                  (clk),
    .rst                  (rst),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_data             (cfg_data),
    .item_valid           (item_valid),
    .item_stall           (item_stall),
    .opcode               (opcode),
    .now_seconds          (now_seconds),
    .byte_count           (byte_count),
    .result_valid         (result_valid),
    .result_stall         (result_stall),
    .rate_bytes_per_second(rate_bytes_per_second),
    .entries_held         (entries_held),
    .fail_count           (fail_count),
    .pending              (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Safety net: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Offers one item and holds it until the block takes it. After acceptance
  // a random gap follows; with no gap valid simply stays high, so the next
  // item goes out back to back.
  task automatic send_item(input logic op, input logic [DATA_W-1:0] now,
                           input logic [COUNT_W-1:0] cnt);
    int gap;
    int roll;
    item_valid  <= 1'b1;
    opcode      <= op;
    now_seconds <= now;
    byte_count  <= cnt;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    roll = $urandom_range(0, 99);
    if (quiet || roll < 55) gap = 0;
    else if (roll < 85) gap = $urandom_range(1, 3);
    else if (roll < 97) gap = $urandom_range(4, 30);
    else gap = $urandom_range(31, 150);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering items and waits until every predicted result has come
  // back. The first edge lets the checker count an item taken at this edge.
  task automatic drain_results();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  // Writes window_seconds; only called while the block is idle.
  task automatic write_window(input int w);
    cfg_valid <= 1'b1;
    cfg_data  <= WIN_W'(w);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    cur_window = w;
  endtask

  // Result side pacing: random stall and run stretches, a quiet mode with no
  // stalls at all, and one long hold-off on request so the block backs up.
  initial begin : result_pacing
    int stall_len;
    int run_len;
    int roll;
    result_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        result_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else if (quiet) begin
        result_stall <= 1'b0;
        @(posedge clk);
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 70) stall_len = $urandom_range(1, 2);
        else if (roll < 95) stall_len = $urandom_range(3, 20);
        else stall_len = $urandom_range(21, 100);
        run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) :
                                                 $urandom_range(1, 12);
        result_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
        result_stall <= 1'b0;
        repeat (run_len) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [DATA_W-1:0]  t;
    logic [COUNT_W-1:0] cnt;
    logic               op;
    int                 roll;
    int                 w;

    cfg_valid   <= 1'b0;
    cfg_data    <= '0;
    item_valid  <= 1'b0;
    opcode      <= OP_RECEIVE;
    now_seconds <= '0;
    byte_count  <= '0;
    rst         <= 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset window of three seconds. A report on an
    // empty history, a zero count and a full count in the same second, then
    // a second entry so that a nonzero rate appears.
    send_item(OP_REPORT, 32'd0, 16'd0);
    send_item(OP_RECEIVE, 32'd0, 16'd0);
    send_item(OP_RECEIVE, 32'd0, 16'hFFFF);
    send_item(OP_RECEIVE, 32'd1, 16'hFFFF);
    send_item(OP_REPORT, 32'd2, 16'h1234);
    // A jump forward trims the old seconds, then time goes backward.
    send_item(OP_RECEIVE, 32'd9, 16'd1234);
    send_item(OP_RECEIVE, 32'd5, 16'd7);
    // The top of the time range, then a wrap to zero: the span between the
    // oldest and second-newest entry is taken modulo two to the 32nd.
    send_item(OP_RECEIVE, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(OP_RECEIVE, 32'd0, 16'd100);
    send_item(OP_RECEIVE, 32'd1, 16'd5);
    // Still below the window, so trimming drops nothing.
    send_item(OP_REPORT, 32'd2, 16'd0);

    // Widest window: consecutive seconds up to the window value, so trimming
    // drops nothing, until the store is full and the oldest entry gets overwritten.
    drain_results();
    write_window(15);
    for (int s = 2; s < 16; s++)
      send_item(OP_RECEIVE, DATA_W'(s), s[0] ? 16'hFFFF : 16'd0);

    // Random phases. Time mostly stays or steps forward by a second, with
    // occasional jumps up to just past the window, small steps back and wild values.
    t = 32'd16;
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_results();
      if (phase == 0) w = 0;
      else if (phase == 1 || phase == PHASES - 1) w = 15;
      else w = $urandom_range(0, 15);
      write_window(w);

      case ($urandom_range(0, 3))
        0: ;
        1: t = '0;
        2: t = 32'hFFFF_FFFF - $urandom_range(0, 40);
        default: t = $urandom;
      endcase

      // One phase backs up the result side for a long stretch while items
      // keep coming; another runs with no idling on either side.
      if (phase == 2) hold_request = 1'b1;
      quiet = (phase == 3);

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Halfway through one phase the sender waits for every result.
        if (phase == 4 && n == ITEMS_PER_PHASE / 2) drain_results();
        roll = $urandom_range(0, 99);
        if (roll < 3) t = $urandom;
        else if (roll < 58) t = t;
        else if (roll < 83) t = t + 1;
        else if (roll < 96) t = t + $urandom_range(2, cur_window + 3);
        else t = t - $urandom_range(1, 5);
        op = ($urandom_range(0, 3) == 0) ? OP_REPORT : OP_RECEIVE;
        roll = $urandom_range(0, 19);
        cnt = (roll == 0) ? '0 : (roll < 3) ? '1 : COUNT_W'($urandom);
        send_item(op, t, cnt);
      end
      quiet = 1'b0;
    end

    drain_results();
    repeat (END_WAIT) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/swrm_pkg.sv
hw/rtl/swrm_ram.sv
hw/rtl/swrm_div.sv
hw/rtl/sliding_window_rate_meter.sv
hw/rtl/swrm_checker.sv
verif/swrm_checker.sv
verif/tb_top.sv
